[design/flsv_pkg.sv]
// shared constants, types and lookup-table builders for the light source vector unit
package flsv_pkg;

  localparam int VEC_FB      = 14;
  localparam int DIR_FB      = 14;
  localparam int POS_W       = 24;
  localparam int DIFF_W      = POS_W + 1;
  localparam int MAG_W       = POS_W;
  localparam int SH_W        = $clog2(MAG_W);
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int NUM_W       = MAG_W + VEC_FB + 1;
  localparam int QUO_W       = VEC_FB + 1;
  localparam int SQ_ST       = ROOT_W;
  localparam int DV_ST       = VEC_FB + 1;
  localparam int POW_DEPTH   = 256;
  localparam int POW_IW      = $clog2(POW_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int REG_W       = 3;

  localparam logic [1:0] MODE_DISTANT = 2'd0;
  localparam logic [1:0] MODE_POINT   = 2'd1;
  localparam logic [1:0] MODE_SPOT    = 2'd2;

  localparam logic [REG_W-1:0] REG_LIGHT_MODE  = 3'd0;
  localparam logic [REG_W-1:0] REG_LIGHT_POS_X = 3'd1;
  localparam logic [REG_W-1:0] REG_LIGHT_POS_Y = 3'd2;
  localparam logic [REG_W-1:0] REG_LIGHT_POS_Z = 3'd3;
  localparam logic [REG_W-1:0] REG_DIRECTION   = 3'd4;
  localparam logic [REG_W-1:0] REG_CONE_COSINE = 3'd5;
  localparam logic [REG_W-1:0] REG_SPOT_EXP    = 3'd6;
  localparam logic [REG_W-1:0] REG_LIGHT_COLOR = 3'd7;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [47:0]        dir;
    logic signed [15:0] cone;
    logic [14:0]        expo;
    logic [23:0]        color;
  } cfg_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic               zero_length;
  } result_t;

  typedef logic [15:0] log_tab_t [POW_DEPTH];
  typedef logic [30:0] exp_tab_t [POW_DEPTH];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = v;
    res = '0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // log2(1 + i/D) in Q.16, one bit per squaring
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] y;
    logic [63:0] r;
    for (int i = 0; i < POW_DEPTH; i++) begin
      y = (64'd1 << 30) + ((64'(i) << 30) / POW_DEPTH);
      r = '0;
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd1 << 31)) begin
          r = r | 64'd1;
          y = y >> 1;
        end
      end
      tab[i] = r[15:0];
    end
    return tab;
  endfunction

  // 2^-(j/D) in Q.30, one square root per fraction bit
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] v;
    for (int j = 0; j < POW_DEPTH; j++) begin
      q = (64'(j) << 16) / POW_DEPTH;
      r = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
        v = q[k] ? (r >> 1) : r;
        r = isqrt64(v << 30);
      end
      tab[j] = r[30:0];
    end
    return tab;
  endfunction

endpackage

[design/flsv_queue.sv]
// two-entry queue between the front and the back end
module flsv_queue import flsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     item_i,
  input  logic      pop_i,
  output item_t     item_o,
  output q_status_t status_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[design/flsv_front.sv]
// front end: takes surface points and forms the light difference vector
module flsv_front import flsv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [23:0] surf_x_i,
  input  logic signed [23:0] surf_y_i,
  input  logic signed [23:0] surf_z_i,
  input  cfg_t               cfg_i,
  input  q_status_t          q_status_i,
  output logic               busy_o,
  output logic               push_o,
  output item_t              item_o
);

  logic  fr_vld_q, fr_vld_d;
  item_t fr_item_q;
  logic  accept;

  assign busy_o = fr_vld_q && q_status_i.full;
  assign accept = start_i && !busy_o;
  assign push_o = fr_vld_q && !q_status_i.full;
  assign item_o = fr_item_q;

  always_comb begin
    fr_vld_d = fr_vld_q;
    if (accept) begin
      fr_vld_d = 1'b1;
    end else if (push_o) begin
      fr_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= 1'b0;
    end else begin
      fr_vld_q <= fr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_item_q.dx <= DIFF_W'(cfg_i.pos_x) - DIFF_W'(surf_x_i);
      fr_item_q.dy <= DIFF_W'(cfg_i.pos_y) - DIFF_W'(surf_y_i);
      fr_item_q.dz <= DIFF_W'(cfg_i.pos_z) - DIFF_W'(surf_z_i);
    end
  end

endmodule

[design/flsv_back.sv]
// back end: normalise, spot cone test and spot power, one beat per cycle
module flsv_back import flsv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    out_valid_o,
  output result_t result_o
);

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();
  localparam int       SP_W    = 22;
  localparam int       T_W     = 27;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic               zero;
    logic               le_cone;
    logic               le_zero;
  } carry_t;

  // normalising shift
  logic signed [DIFF_W-1:0] s1_d [3];
  logic [MAG_W-1:0]         s1_mag [3];
  logic [MAG_W-1:0]         s1_max;
  logic [SH_W-1:0]          s1_sh;
  logic [MAG_W-1:0]         n1_a_q [3];
  logic [2:0]               n1_neg_q;
  logic                     n1_zero_q;
  logic                     n1_vld_q;

  // squares
  logic [SQ_W-1:0]  n2_sq_q [3];
  logic [MAG_W-1:0] n2_a_q [3];
  logic [2:0]       n2_neg_q;
  logic             n2_zero_q;
  logic             n2_vld_q;

  // square root, two radicand bits per stage
  logic [SUM_W-1:0]  sr_rad_q  [SQ_ST+1];
  logic [REM_W-1:0]  sr_rem_q  [SQ_ST+1];
  logic [ROOT_W-1:0] sr_root_q [SQ_ST+1];
  logic [MAG_W-1:0]  sr_a_q    [SQ_ST+1][3];
  logic [2:0]        sr_neg_q  [SQ_ST+1];
  logic              sr_zero_q [SQ_ST+1];
  logic              sr_vld_q  [SQ_ST+1];
  logic [SUM_W-1:0]  sr_rad_d  [SQ_ST];
  logic [REM_W-1:0]  sr_rem_d  [SQ_ST];
  logic [ROOT_W-1:0] sr_root_d [SQ_ST];
  logic [REM_W+1:0]  sr_remn   [SQ_ST];
  logic [REM_W-1:0]  sr_trial  [SQ_ST];

  // division, one quotient bit per stage
  logic [NUM_W-1:0]  dv_rem_q  [DV_ST+1][3];
  logic [QUO_W-1:0]  dv_quo_q  [DV_ST+1][3];
  logic [ROOT_W-1:0] dv_r_q    [DV_ST+1];
  logic [2:0]        dv_neg_q  [DV_ST+1];
  logic              dv_zero_q [DV_ST+1];
  logic              dv_vld_q  [DV_ST+1];
  logic [NUM_W-1:0]  dv_rem_d  [DV_ST][3];
  logic [QUO_W-1:0]  dv_quo_d  [DV_ST][3];
  logic [NUM_W-1:0]  dv_div    [DV_ST];

  // signed vector, dot product, spot value
  logic signed [15:0]   vs_v_q [3];
  logic                 vs_zero_q;
  logic                 vs_vld_q;
  logic signed [15:0]   dir_s [3];
  logic signed [31:0]   dp_p_q [3];
  logic signed [15:0]   dp_v_q [3];
  logic                 dp_zero_q;
  logic                 dp_vld_q;
  logic signed [33:0]   sp_dot;
  logic signed [34:0]   sp_negd;
  logic [34:0]          sp_mag;
  logic [20:0]          sp_rm;
  logic signed [SP_W-1:0] sp_d;
  logic signed [SP_W-1:0] sp_q;
  logic signed [15:0]   sp_v_q [3];
  logic                 sp_zero_q;
  logic                 sp_vld_q;

  // power through log and exp tables
  logic [14:0]       p1_x;
  logic [3:0]        p1_lead;
  logic [30:0]       p1_mw;
  logic [POW_IW-1:0] p1_idx;
  logic [3:0]        p1_lead_q;
  logic [15:0]       p1_log_q;
  carry_t            p1_cr_d, p1_cr_q;
  logic              p1_vld_q;
  logic [19:0]       p2_g;
  logic [34:0]       p2_t;
  logic [T_W-1:0]    p2_t_q;
  carry_t            p2_cr_q;
  logic              p2_vld_q;
  logic [10:0]       p3_n;
  logic [30:0]       p3_e_q;
  logic              p3_kill_q;
  logic [5:0]        p3_sh_q;
  carry_t            p3_cr_q;
  logic              p3_vld_q;
  logic [7:0]        col [3];
  logic [38:0]       p4_prod_q [3];
  logic              p4_kill_q;
  logic [5:0]        p4_sh_q;
  carry_t            p4_cr_q;
  logic              p4_vld_q;

  logic [38:0]        fin_x [3];
  logic [15:0]        fin_pow [3];
  logic [15:0]        fin_rgb [3];
  logic signed [16:0] fin_dir [3];
  logic signed [15:0] fin_vec [3];
  result_t            out_d, out_q;
  logic               out_vld_q;

  assign s1_d[0] = item_i.dx;
  assign s1_d[1] = item_i.dy;
  assign s1_d[2] = item_i.dz;

  assign dir_s[0] = cfg_i.dir[47:32];
  assign dir_s[1] = cfg_i.dir[31:16];
  assign dir_s[2] = cfg_i.dir[15:0];

  assign col[0] = cfg_i.color[23:16];
  assign col[1] = cfg_i.color[15:8];
  assign col[2] = cfg_i.color[7:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_mag[k] = s1_d[k][DIFF_W-1] ? MAG_W'(-s1_d[k]) : MAG_W'(s1_d[k]);
    end
    s1_max = s1_mag[0];
    if (s1_mag[1] > s1_max) s1_max = s1_mag[1];
    if (s1_mag[2] > s1_max) s1_max = s1_mag[2];
    s1_sh = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (s1_max[b]) s1_sh = SH_W'(MAG_W - 1 - b);
    end
  end

  always_comb begin
    for (int i = 0; i < SQ_ST; i++) begin
      sr_remn[i]  = {sr_rem_q[i], sr_rad_q[i][SUM_W-1 -: 2]};
      sr_trial[i] = {sr_root_q[i], 2'b01};
      sr_rad_d[i] = {sr_rad_q[i][SUM_W-3:0], 2'b00};
      if (sr_remn[i] >= (REM_W+2)'(sr_trial[i])) begin
        sr_rem_d[i]  = REM_W'(sr_remn[i] - (REM_W+2)'(sr_trial[i]));
        sr_root_d[i] = {sr_root_q[i][ROOT_W-2:0], 1'b1};
      end else begin
        sr_rem_d[i]  = REM_W'(sr_remn[i]);
        sr_root_d[i] = {sr_root_q[i][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DV_ST; i++) begin
      dv_div[i] = NUM_W'(dv_r_q[i]) << (VEC_FB - i);
      for (int k = 0; k < 3; k++) begin
        if (dv_rem_q[i][k] >= dv_div[i]) begin
          dv_rem_d[i][k] = dv_rem_q[i][k] - dv_div[i];
          dv_quo_d[i][k] = dv_quo_q[i][k] | (QUO_W'(1) << (VEC_FB - i));
        end else begin
          dv_rem_d[i][k] = dv_rem_q[i][k];
          dv_quo_d[i][k] = dv_quo_q[i][k];
        end
      end
    end
  end

  // s = -(L . S), rounded half away from zero and capped at one
  always_comb begin
    sp_dot  = 34'(dp_p_q[0]) + 34'(dp_p_q[1]) + 34'(dp_p_q[2]);
    sp_negd = -35'(sp_dot);
    sp_mag  = sp_negd[34] ? 35'(-sp_negd) : 35'(sp_negd);
    sp_rm   = 21'((sp_mag + (35'd1 << (VEC_FB - 1))) >> VEC_FB);
    sp_d    = sp_negd[34] ? -$signed({1'b0, sp_rm}) : $signed({1'b0, sp_rm});
    if (sp_d > SP_W'(1 << DIR_FB)) sp_d = SP_W'(1 << DIR_FB);
  end

  always_comb begin
    p1_x    = sp_q[14:0];
    p1_lead = '0;
    for (int b = 0; b < 15; b++) begin
      if (p1_x[b]) p1_lead = 4'(b);
    end
    p1_mw           = {p1_x, 16'h0000} >> p1_lead;
    p1_idx          = p1_mw[15 -: POW_IW];
    p1_cr_d.vx      = sp_v_q[0];
    p1_cr_d.vy      = sp_v_q[1];
    p1_cr_d.vz      = sp_v_q[2];
    p1_cr_d.zero    = sp_zero_q;
    p1_cr_d.le_cone = (sp_q <= SP_W'(cfg_i.cone));
    p1_cr_d.le_zero = (sp_q <= SP_W'(0));
  end

  assign p2_g = {4'(4'd14 - p1_lead_q), 16'h0000} - 20'(p1_log_q);
  assign p2_t = 35'(p2_g) * 35'(cfg_i.expo);
  assign p3_n = p2_t_q[T_W-1:16];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fin_x[k]   = p4_prod_q[k] >> p4_sh_q;
      fin_pow[k] = p4_kill_q ? 16'h0000 : 16'((fin_x[k] + 39'd1) >> 1);
      fin_dir[k] = 17'(dir_s[k]) <<< (VEC_FB - DIR_FB);
      if (fin_dir[k] > 17'sd16384) fin_dir[k] = 17'sd16384;
      if (fin_dir[k] < -17'sd16384) fin_dir[k] = -17'sd16384;
    end
    fin_vec[0] = p4_cr_q.vx;
    fin_vec[1] = p4_cr_q.vy;
    fin_vec[2] = p4_cr_q.vz;
    out_d.zero_length = p4_cr_q.zero;
    for (int k = 0; k < 3; k++) begin
      fin_rgb[k] = {col[k], 8'h00};
    end
    unique case (cfg_i.mode)
      MODE_DISTANT: begin
        for (int k = 0; k < 3; k++) fin_vec[k] = 16'(fin_dir[k]);
        out_d.zero_length = 1'b0;
      end
      MODE_SPOT: begin
        for (int k = 0; k < 3; k++) begin
          if (p4_cr_q.le_cone) begin
            fin_rgb[k] = 16'h0000;
          end else if (p4_cr_q.le_zero) begin
            if (cfg_i.expo != '0) fin_rgb[k] = 16'h0000;
          end else begin
            fin_rgb[k] = fin_pow[k];
          end
        end
      end
      default: begin
      end
    endcase
    out_d.vec_x = fin_vec[0];
    out_d.vec_y = fin_vec[1];
    out_d.vec_z = fin_vec[2];
    out_d.red   = fin_rgb[0];
    out_d.green = fin_rgb[1];
    out_d.blue  = fin_rgb[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_vld_q  <= 1'b0;
      n2_vld_q  <= 1'b0;
      for (int i = 0; i <= SQ_ST; i++) sr_vld_q[i] <= 1'b0;
      for (int i = 0; i <= DV_ST; i++) dv_vld_q[i] <= 1'b0;
      vs_vld_q  <= 1'b0;
      dp_vld_q  <= 1'b0;
      sp_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      n1_vld_q    <= in_valid_i;
      n2_vld_q    <= n1_vld_q;
      sr_vld_q[0] <= n2_vld_q;
      for (int i = 0; i < SQ_ST; i++) sr_vld_q[i+1] <= sr_vld_q[i];
      dv_vld_q[0] <= sr_vld_q[SQ_ST];
      for (int i = 0; i < DV_ST; i++) dv_vld_q[i+1] <= dv_vld_q[i];
      vs_vld_q    <= dv_vld_q[DV_ST];
      dp_vld_q    <= vs_vld_q;
      sp_vld_q    <= dp_vld_q;
      p1_vld_q    <= sp_vld_q;
      p2_vld_q    <= p1_vld_q;
      p3_vld_q    <= p2_vld_q;
      p4_vld_q    <= p3_vld_q;
      out_vld_q   <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      n1_a_q[k]   <= s1_mag[k] << s1_sh;
      n1_neg_q[k] <= s1_d[k][DIFF_W-1];
    end
    n1_zero_q <= (s1_max == '0);

    for (int k = 0; k < 3; k++) begin
      n2_sq_q[k] <= SQ_W'(n1_a_q[k]) * SQ_W'(n1_a_q[k]);
      n2_a_q[k]  <= n1_a_q[k];
    end
    n2_neg_q  <= n1_neg_q;
    n2_zero_q <= n1_zero_q;

    sr_rad_q[0]  <= SUM_W'(n2_sq_q[0]) + SUM_W'(n2_sq_q[1]) + SUM_W'(n2_sq_q[2]);
    sr_rem_q[0]  <= '0;
    sr_root_q[0] <= '0;
    for (int k = 0; k < 3; k++) sr_a_q[0][k] <= n2_a_q[k];
    sr_neg_q[0]  <= n2_neg_q;
    sr_zero_q[0] <= n2_zero_q;
    for (int i = 0; i < SQ_ST; i++) begin
      sr_rad_q[i+1]  <= sr_rad_d[i];
      sr_rem_q[i+1]  <= sr_rem_d[i];
      sr_root_q[i+1] <= sr_root_d[i];
      for (int k = 0; k < 3; k++) sr_a_q[i+1][k] <= sr_a_q[i][k];
      sr_neg_q[i+1]  <= sr_neg_q[i];
      sr_zero_q[i+1] <= sr_zero_q[i];
    end

    // numerator carries the half-divisor for round to nearest
    for (int k = 0; k < 3; k++) begin
      dv_rem_q[0][k] <= NUM_W'({sr_a_q[SQ_ST][k], VEC_FB'(0)}) +
                        NUM_W'(sr_root_q[SQ_ST] >> 1);
      dv_quo_q[0][k] <= '0;
    end
    dv_r_q[0]    <= sr_root_q[SQ_ST];
    dv_neg_q[0]  <= sr_neg_q[SQ_ST];
    dv_zero_q[0] <= sr_zero_q[SQ_ST];
    for (int i = 0; i < DV_ST; i++) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem_q[i+1][k] <= dv_rem_d[i][k];
        dv_quo_q[i+1][k] <= dv_quo_d[i][k];
      end
      dv_r_q[i+1]    <= dv_r_q[i];
      dv_neg_q[i+1]  <= dv_neg_q[i];
      dv_zero_q[i+1] <= dv_zero_q[i];
    end

    for (int k = 0; k < 3; k++) begin
      if (dv_zero_q[DV_ST]) begin
        vs_v_q[k] <= '0;
      end else if (dv_neg_q[DV_ST][k]) begin
        vs_v_q[k] <= -$signed(16'(dv_quo_q[DV_ST][k]));
      end else begin
        vs_v_q[k] <= $signed(16'(dv_quo_q[DV_ST][k]));
      end
    end
    vs_zero_q <= dv_zero_q[DV_ST];

    for (int k = 0; k < 3; k++) begin
      dp_p_q[k] <= vs_v_q[k] * dir_s[k];
      dp_v_q[k] <= vs_v_q[k];
    end
    dp_zero_q <= vs_zero_q;

    sp_q <= sp_d;
    for (int k = 0; k < 3; k++) sp_v_q[k] <= dp_v_q[k];
    sp_zero_q <= dp_zero_q;

    p1_lead_q <= p1_lead;
    p1_log_q  <= LOG_TAB[p1_idx];
    p1_cr_q   <= p1_cr_d;

    p2_t_q  <= p2_t[34:8];
    p2_cr_q <= p1_cr_q;

    p3_e_q    <= EXP_TAB[p2_t_q[15 -: POW_IW]];
    p3_kill_q <= (p3_n >= 11'd18);
    p3_sh_q   <= 6'd21 + 6'(p3_n[4:0]);
    p3_cr_q   <= p2_cr_q;

    for (int k = 0; k < 3; k++) p4_prod_q[k] <= 39'(col[k]) * 39'(p3_e_q);
    p4_kill_q <= p3_kill_q;
    p4_sh_q   <= p3_sh_q;
    p4_cr_q   <= p3_cr_q;

    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = out_q;

endmodule

[design/filter_light_source_vector_core.sv]
// top level of the light source vector unit: config registers, front, queue, back
//
//  channel  | handshake                  | beat
//  ---------+----------------------------+----------------------------------------
//  input    | start, busy                | surf_x_i, surf_y_i, surf_z_i
//  config   | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//  result   | valid_o (one-cycle strobe) | vec_*_o, red/green/blue_out_o, zero_length_o
//
// one point per cycle sustained while busy is low
// latency is set mainly by the 25-stage square root and the 15-stage quotient pipeline
// reset clears the pipeline and loads the config registers with their defaults
// the result side has no back-pressure; busy only rises if the queue fills
module filter_light_source_vector_core import flsv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] surf_x_i,
  input  logic signed [23:0] surf_y_i,
  input  logic signed [23:0] surf_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [REG_W-1:0]   cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  output logic               valid_o,
  output logic signed [15:0] vec_x_o,
  output logic signed [15:0] vec_y_o,
  output logic signed [15:0] vec_z_o,
  output logic [15:0]        red_out_o,
  output logic [15:0]        green_out_o,
  output logic [15:0]        blue_out_o,
  output logic               zero_length_o
);

  cfg_t      cfg_q;
  q_status_t q_status;
  logic      push;
  item_t     fr_item;
  item_t     q_item;
  result_t   result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_DISTANT;
      cfg_q.pos_x <= '0;
      cfg_q.pos_y <= '0;
      cfg_q.pos_z <= '0;
      cfg_q.dir   <= '0;
      cfg_q.cone  <= -16'sd16384;
      cfg_q.expo  <= 15'd256;
      cfg_q.color <= 24'hFFFFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LIGHT_MODE:  cfg_q.mode  <= cfg_data_i[1:0];
        REG_LIGHT_POS_X: cfg_q.pos_x <= cfg_data_i[23:0];
        REG_LIGHT_POS_Y: cfg_q.pos_y <= cfg_data_i[23:0];
        REG_LIGHT_POS_Z: cfg_q.pos_z <= cfg_data_i[23:0];
        REG_DIRECTION:   cfg_q.dir   <= cfg_data_i;
        REG_CONE_COSINE: cfg_q.cone  <= cfg_data_i[15:0];
        REG_SPOT_EXP:    cfg_q.expo  <= cfg_data_i[14:0];
        REG_LIGHT_COLOR: cfg_q.color <= cfg_data_i[23:0];
        default: begin
        end
      endcase
    end
  end

  flsv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .surf_x_i   (surf_x_i),
    .surf_y_i   (surf_y_i),
    .surf_z_i   (surf_z_i),
    .cfg_i      (cfg_q),
    .q_status_i (q_status),
    .busy_o     (busy),
    .push_o     (push),
    .item_o     (fr_item)
  );

  flsv_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (fr_item),
    .pop_i    (!q_status.empty),
    .item_o   (q_item),
    .status_o (q_status)
  );

  flsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_status.empty),
    .item_i      (q_item),
    .cfg_i       (cfg_q),
    .out_valid_o (valid_o),
    .result_o    (result)
  );

  assign vec_x_o       = result.vec_x;
  assign vec_y_o       = result.vec_y;
  assign vec_z_o       = result.vec_z;
  assign red_out_o     = result.red;
  assign green_out_o   = result.green;
  assign blue_out_o    = result.blue;
  assign zero_length_o = result.zero_length;

endmodule

[design/flsv_checker.sv]
// port-level checks for the light source vector unit, bound to the top level
module flsv_checker import flsv_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               valid_o,
  input logic signed [15:0] vec_x_o,
  input logic signed [15:0] vec_y_o,
  input logic signed [15:0] vec_z_o,
  input logic               zero_length_o
);

  // coincident points give a null vector
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_length_o |-> vec_x_o == 16'sd0 && vec_y_o == 16'sd0 &&
                                 vec_z_o == 16'sd0)
    else $error("zero_length beat with non-zero vector");

  // every component stays within plus or minus one
  a_vec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> vec_x_o <= 16'sd16384 && vec_x_o >= -16'sd16384 &&
                vec_y_o <= 16'sd16384 && vec_y_o >= -16'sd16384 &&
                vec_z_o <= 16'sd16384 && vec_z_o >= -16'sd16384)
    else $error("vector component out of range");

  // the back end never stalls, so the input side never backs up
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start) |-> !busy)
    else $error("input stalled");

  // config beats are always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config beat refused");

endmodule

bind filter_light_source_vector_core flsv_checker u_flsv_checker (.*);

[tb/tb.sv]
// self-checking testbench for the light source vector unit
module tb;
  import flsv_pkg::*;

  typedef struct {
    logic [15:0] vx, vy, vz, r, g, b;
    logic        zl;
  } light_res_t;

  class light_scoreboard;
    light_res_t pending[$];
    int         errors;

    function void note(light_res_t e);
      pending.push_back(e);
    endfunction

    function void check(light_res_t got);
      light_res_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (got.vx !== e.vx) report($sformatf("vec_x %h exp %h", got.vx, e.vx));
      if (got.vy !== e.vy) report($sformatf("vec_y %h exp %h", got.vy, e.vy));
      if (got.vz !== e.vz) report($sformatf("vec_z %h exp %h", got.vz, e.vz));
      if (got.r !== e.r) report($sformatf("red %h exp %h", got.r, e.r));
      if (got.g !== e.g) report($sformatf("green %h exp %h", got.g, e.g));
      if (got.b !== e.b) report($sformatf("blue %h exp %h", got.b, e.b));
      if (got.zl !== e.zl) report($sformatf("zero_length %b exp %b", got.zl, e.zl));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic start = 0, cfg_valid_i = 0;
  logic signed [23:0] surf_x_i = 0, surf_y_i = 0, surf_z_i = 0;
  logic [REG_W-1:0] cfg_index_i = REG_LIGHT_MODE;
  logic [47:0] cfg_data_i = 0;
  logic busy, cfg_ready_o, valid_o, zero_length_o;
  logic signed [15:0] vec_x_o, vec_y_o, vec_z_o;
  logic [15:0] red_out_o, green_out_o, blue_out_o;

  filter_light_source_vector_core i_dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  light_scoreboard sb = new();
  // shadow copy of the light registers
  logic [1:0]  l_mode;
  logic [23:0] l_px, l_py, l_pz, l_col;
  logic [47:0] l_dir;
  logic [15:0] l_cone;
  logic [14:0] l_exp;
  int unsigned cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && valid_o)
      sb.check('{vec_x_o, vec_y_o, vec_z_o, red_out_o, green_out_o, blue_out_o, zero_length_o});

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned log2_entry(longint unsigned i);
    longint unsigned y, r;
    y = (64'd1 << 30) + ((i << 30) / POW_DEPTH);
    r = 0;
    repeat (16) begin
      y = (y * y) >> 30;
      r <<= 1;
      if (y >= (64'd1 << 31)) begin
        r |= 1;
        y >>= 1;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned exp2_entry(longint unsigned q);
    longint unsigned r, v;
    r = 64'd1 << 30;
    for (int k = 0; k < 16; k++) begin
      v = q[k] ? (r >> 1) : r;
      r = sqrt_floor(v << 30);
    end
    return r;
  endfunction

  function automatic light_res_t light_at(logic [23:0] sx, logic [23:0] sy, logic [23:0] sz);
    light_res_t o;
    longint v[3], ax[3], d[3];
    longint unsigned col[3], res[3], mx, sum, r, a, qv, e, g, t, j, q, m;
    longint dot, sp, cc, c;
    int p, n;
    logic [23:0] ps[3], ss[3];
    ps = '{l_px, l_py, l_pz};
    ss = '{sx, sy, sz};
    o.zl = 0;
    for (int k = 0; k < 3; k++) begin
      ax[k] = longint'($signed(l_dir[32-16*k +: 16]));
      col[k] = l_col[16-8*k +: 8];
      res[k] = col[k] << 8;
      v[k] = 0;
    end
    if (l_mode == MODE_DISTANT) begin
      for (int k = 0; k < 3; k++) begin
        c = ax[k];
        v[k] = c > 16384 ? 16384 : (c < -16384 ? -16384 : c);
      end
    end else begin
      mx = 0;
      for (int k = 0; k < 3; k++) begin
        d[k] = longint'($signed(ps[k])) - longint'($signed(ss[k]));
        a = d[k] < 0 ? -d[k] : d[k];
        if (a > mx) mx = a;
      end
      if (mx == 0) o.zl = 1;
      else begin
        while (mx < (64'd1 << 23)) begin
          mx <<= 1;
          for (int k = 0; k < 3; k++) d[k] *= 2;
        end
        sum = 0;
        for (int k = 0; k < 3; k++) sum += d[k] * d[k];
        r = sqrt_floor(sum);
        for (int k = 0; k < 3; k++) begin
          a = d[k] < 0 ? -d[k] : d[k];
          qv = ((a << 14) + (r >> 1)) / r;
          if (qv > 16384) qv = 16384;
          v[k] = d[k] < 0 ? -longint'(qv) : longint'(qv);
        end
      end
      if (l_mode == MODE_SPOT) begin
        dot = -(v[0] * ax[0] + v[1] * ax[1] + v[2] * ax[2]);
        // round half away from zero
        sp = dot < 0 ? -((-dot + 8192) >>> 14) : ((dot + 8192) >>> 14);
        cc = longint'($signed(l_cone));
        if (sp > 16384) sp = 16384;
        if (sp <= cc) res = '{0, 0, 0};
        else if (sp <= 0) begin
          if (l_exp != 0) res = '{0, 0, 0};
        end else begin
          p = 0;
          while (p < 14 && (sp >> (p + 1)) != 0) p++;
          m = ((unsigned'(sp) << 16) >> p) & 16'hFFFF;
          g = (64'(14 - p) << 16) - log2_entry((m * POW_DEPTH) >> 16);
          t = (g * l_exp) >> 8;
          n = (t >> 16) > 63 ? 63 : int'(t >> 16);
          j = ((t & 16'hFFFF) * POW_DEPTH) >> 16;
          q = (j << 16) / POW_DEPTH;
          e = exp2_entry(q);
          for (int k = 0; k < 3; k++)
            res[k] = n >= 40 ? 0 : ((col[k] * e + (64'd1 << (21 + n))) >> (22 + n));
        end
      end
    end
    o.vx = v[0][15:0]; o.vy = v[1][15:0]; o.vz = v[2][15:0];
    o.r = res[0][15:0]; o.g = res[1][15:0]; o.b = res[2][15:0];
    return o;
  endfunction

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(logic [REG_W-1:0] idx, logic [47:0] val);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    case (idx)
      REG_LIGHT_MODE:  l_mode = val[1:0];
      REG_LIGHT_POS_X: l_px = val[23:0];
      REG_LIGHT_POS_Y: l_py = val[23:0];
      REG_LIGHT_POS_Z: l_pz = val[23:0];
      REG_DIRECTION:   l_dir = val;
      REG_CONE_COSINE: l_cone = val[15:0];
      REG_SPOT_EXP:    l_exp = val[14:0];
      default:         l_col = val[23:0];
    endcase
  endtask

  // one surface point beat, with an optional idle gap before it
  task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 9) : 0;
    if (w != 0) begin
      start <= 0;
      repeat (w) @(posedge clk_i);
    end
    start <= 1;
    surf_x_i <= x; surf_y_i <= y; surf_z_i <= z;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note(light_at(x, y, z));
  endtask

  function automatic logic [47:0] rand_dir();
    logic [15:0] c[3];
    for (int k = 0; k < 3; k++)
      case ($urandom_range(0, 3))
        0: c[k] = 16'sd16384;
        1: c[k] = -16'sd16384;
        2: c[k] = 16'($urandom_range(0, 32767) - 16384);
        default: c[k] = 16'($urandom);
      endcase
    return {c[0], c[1], c[2]};
  endfunction

  function automatic logic [23:0] near(logic [23:0] base);
    case ($urandom_range(0, 3))
      0: return base;
      1: return 24'(base + $urandom_range(0, 15) - 8);
      2: return 24'(base + $urandom_range(0, 65535) - 32768);
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [23:0] ext[4];
    bit gaps;
    ext = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
    l_mode = MODE_DISTANT; l_px = 0; l_py = 0; l_pz = 0; l_dir = 0;
    l_cone = -16'sd16384; l_exp = 256; l_col = 24'hFFFFFF;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset defaults, then each mode with edge points
    send_point(0, 0, 0, 0);
    write_reg(REG_DIRECTION, {16'sd16384, -16'sd16384, 16'h8000});
    for (int i = 0; i < 4; i++) send_point(ext[i], ext[3-i], ext[i], 0);
    drain();
    write_reg(REG_LIGHT_MODE, MODE_POINT);
    write_reg(REG_LIGHT_POS_X, 24'h7FFFFF);
    write_reg(REG_LIGHT_POS_Y, 24'h800000);
    write_reg(REG_LIGHT_POS_Z, 24'h000100);
    send_point(24'h7FFFFF, 24'h800000, 24'h000100, 0);
    send_point(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 0);
    send_point(24'h7FFFFF, 24'h800000, 24'h000101, 0);
    drain();
    write_reg(REG_LIGHT_MODE, 2'd3);
    send_point(0, 0, 0, 0);
    drain();
    write_reg(REG_LIGHT_MODE, MODE_SPOT);
    write_reg(REG_LIGHT_POS_X, 0);
    write_reg(REG_LIGHT_POS_Y, 0);
    write_reg(REG_LIGHT_POS_Z, 24'h001000);
    write_reg(REG_DIRECTION, {16'd0, 16'd0, -16'sd16384});
    write_reg(REG_CONE_COSINE, 16'h8000);
    write_reg(REG_SPOT_EXP, 0);
    write_reg(REG_LIGHT_COLOR, 24'h80FF01);
    send_point(0, 0, 0, 0);
    send_point(24'h000100, 0, 0, 0);
    drain();
    write_reg(REG_SPOT_EXP, 15'h7FFF);
    send_point(0, 0, 0, 0);
    send_point(24'h000010, 24'h000020, 0, 0);
    drain();
    write_reg(REG_CONE_COSINE, 16'sd16384);
    send_point(0, 0, 0, 0);
    drain();

    // random phases, each with a fresh light set-up
    for (int ph = 0; ph < 25; ph++) begin
      write_reg(REG_LIGHT_MODE, ph % 8 == 7 ? 48'(3) : 48'($urandom_range(0, 2)));
      write_reg(REG_LIGHT_POS_X, 48'($urandom));
      write_reg(REG_LIGHT_POS_Y, 48'($urandom));
      write_reg(REG_LIGHT_POS_Z, 48'($urandom));
      write_reg(REG_DIRECTION, rand_dir());
      write_reg(REG_CONE_COSINE, ph % 5 == 0 ? 48'(16'h8000)
                                 : 48'(16'($urandom_range(0, 32768) - 16384)));
      write_reg(REG_SPOT_EXP, ph % 6 == 0 ? 48'(0) : (ph % 6 == 1 ? 48'(15'h7FFF)
                              : 48'($urandom_range(0, 2048))));
      write_reg(REG_LIGHT_COLOR, ph % 4 == 0 ? 48'(24'hFFFFFF) : 48'(24'($urandom)));
      gaps = ph % 3 != 1;
      for (int i = 0; i < 50; i++)
        send_point(near(l_px), near(l_py), near(l_pz), gaps);
      drain();
    end

    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
